>>> design/term_count_by_size_dp_macros.svh
// assertion helpers shared by the term counter modules
`ifndef TERM_COUNT_BY_SIZE_DP_MACROS_SVH
`define TERM_COUNT_BY_SIZE_DP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define TCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  // problem limits
  localparam int MAX_SIZE  = 32;
  localparam int MAX_ARITY = 6;

  // field widths
  localparam int SIZE_IN_W   = 6;
  localparam int COUNT_W     = 32;
  localparam int SYM_W       = 16;
  localparam int MAXAR_REG_W = 3;
  localparam int CFG_DATA_W  = 16;

  // derived widths
  localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
  localparam int IDX_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W      = (SIZE_W > MAXAR_REG_W) ? SIZE_W : MAXAR_REG_W;
  localparam int ARITY_W    = $clog2(MAX_ARITY + 1);
  localparam int MEMO_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int MEMO_AW    = $clog2(MEMO_DEPTH);
  localparam int NUM_REGS   = MAX_ARITY + 2;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS0  = CFG_IDX_W'(1);

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic               issue;
    logic               use_sym;
    logic [SYM_W-1:0]   sym;
    logic               clear;
    logic [COUNT_W-1:0] init;
  } mac_ctl_t;

  // memo entry for (size - 1, groups - 1)
  function automatic logic [MEMO_AW-1:0] memo_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return MEMO_AW'(row) * MEMO_AW'(MAX_SIZE) + MEMO_AW'(col);
  endfunction

endpackage

`default_nettype wire

>>> design/tcs_ram.sv
`default_nettype none

module tcs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/tcs_mac.sv
`default_nettype none
`include "term_count_by_size_dp_macros.svh"

module tcs_mac
  import tcs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_ctl_t           ctl_i,
  input  wire logic [COUNT_W-1:0] terms_i,
  input  wire logic [COUNT_W-1:0] memo_i,
  output logic      [COUNT_W-1:0] acc_o,
  output logic                    busy_o
);

  logic               s1_valid_q;
  logic               s1_use_sym_q;
  logic [SYM_W-1:0]   s1_sym_q;
  logic               s2_valid_q;
  logic [COUNT_W-1:0] prod_q;
  logic [COUNT_W-1:0] acc_q;
  logic [COUNT_W-1:0] op_a;
  logic [COUNT_W-1:0] prod_d;

  // first operand: symbol count or term count
  assign op_a   = s1_use_sym_q ? COUNT_W'(s1_sym_q) : terms_i;
  assign prod_d = op_a * memo_i;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctl_i.issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  // operand select travels with the memory read
  always_ff @(posedge clk_i) begin
    s1_use_sym_q <= ctl_i.use_sym;
    s1_sym_q     <= ctl_i.sym;
  end

  // product register, then accumulate modulo 2^32
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_i.clear) begin
      acc_q <= ctl_i.init;
    end else if (s2_valid_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = s1_valid_q | s2_valid_q;

  `TCS_ASSERT_IMPL(a_clear_when_idle, clk_i, rst_ni, ctl_i.clear, !s1_valid_q && !s2_valid_q, "accumulator cleared with products in flight")
  `TCS_ASSERT_IMPL(a_no_issue_on_clear, clk_i, rst_ni, ctl_i.clear, !ctl_i.issue, "step issued in the clear cycle")
  `TCS_ASSERT_NEXT(a_stage_follow, clk_i, rst_ni, s1_valid_q, s2_valid_q, "read stage not followed by product stage")

endmodule

`default_nettype wire

>>> design/term_count_by_size_dp.sv
// Term counter by size with a memo of arrangement counts.
// Configuration: write cfg_we_i with cfg_index_i (0 max arity, 1..7 symbol counts
// for arity 0..6) and cfg_wdata_i, only while the block is idle. Any write of a
// known register invalidates the whole memo; reset clears registers and invalidates the memo.
// Request channel: in_valid_i / in_stall_o with func_i, term_size_i, group_count_i.
// Result channel: out_valid_o / out_stall_i with count_o, one result per request.
// A request whose rows are already filled is answered from the memo, one whose
// fields are out of range with a count of zero. Otherwise rows are filled bottom-up
// from the first unfilled row; row m, column i accumulates one product per step,
// steps being m-i+1 for groups, min(arity, m-1) for terms.
// Each product comes from the single multiply-accumulate pipeline, which reads one
// memo entry per cycle while the sequencer issues steps.
// One request is in work at a time; in_stall_o is high while it is.
// A finished result waits in the output register while out_stall_i is high;
// the next request is accepted meanwhile, and its result waits until the
// register frees.
`default_nettype none
`include "term_count_by_size_dp_macros.svh"

module term_count_by_size_dp
  import tcs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic [SIZE_IN_W-1:0]  term_size_i,
  input  wire logic [SIZE_IN_W-1:0]  group_count_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COUNT_W-1:0]    count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL_SETUP,
    S_ISSUE,
    S_DRAIN,
    S_WRITE,
    S_QRD,
    S_QWAIT,
    S_RESP
  } state_e;

  state_e state_q;

  // configuration
  logic [MAXAR_REG_W-1:0] max_arity_q;
  logic [SYM_W-1:0]       sym_q [MAX_ARITY+1];
  logic                   cfg_hit;

  // sequencer
  logic [SIZE_W-1:0]  fill_q;
  logic [SIZE_W-1:0]  row_q;
  logic [SIZE_W-1:0]  col_q;
  logic [SIZE_W-1:0]  n_q;
  logic [SIZE_W-1:0]  g_q;
  logic [CNT_W-1:0]   k_q;
  logic [CNT_W-1:0]   lim_q;
  logic [COUNT_W-1:0] res_q;
  logic               out_valid_q;
  logic [COUNT_W-1:0] count_q;

  logic               in_bad;
  logic [SIZE_W-1:0]  n_in;
  logic [SIZE_W-1:0]  g_in;
  logic [CNT_W-1:0]   top_arity;
  logic [CNT_W-1:0]   row_m1;
  logic [CNT_W-1:0]   step_lim;

  // memories and datapath
  mac_ctl_t           mac_ctl;
  logic [COUNT_W-1:0] mac_acc;
  logic               mac_busy;
  logic               memo_we;
  logic [MEMO_AW-1:0] memo_waddr;
  logic               memo_re;
  logic [MEMO_AW-1:0] memo_raddr;
  logic [COUNT_W-1:0] memo_rdata;
  logic               terms_we;
  logic [IDX_W-1:0]   terms_waddr;
  logic [IDX_W-1:0]   terms_raddr;
  logic [COUNT_W-1:0] terms_rdata;

  // configuration writes
  assign cfg_hit = cfg_we_i && (int'(cfg_index_i) < NUM_REGS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_arity_q <= '0;
      for (int a = 0; a <= MAX_ARITY; a++) begin
        sym_q[a] <= '0;
      end
    end else if (cfg_hit) begin
      unique case (cfg_index_i)
        REG_MAX_ARITY: max_arity_q <= cfg_wdata_i[MAXAR_REG_W-1:0];
        default:       sym_q[ARITY_W'(cfg_index_i - REG_SYMBOLS0)] <= cfg_wdata_i;
      endcase
    end
  end

  // request checks
  assign in_bad = (term_size_i == '0) || (int'(term_size_i) > MAX_SIZE) ||
                  (func_i && ((group_count_i == '0) || (group_count_i > term_size_i)));
  assign n_in   = SIZE_W'(term_size_i);
  assign g_in   = func_i ? SIZE_W'(group_count_i) : SIZE_W'(1);

  // step count of the column being set up
  always_comb begin
    top_arity = (int'(max_arity_q) > MAX_ARITY) ? CNT_W'(MAX_ARITY) : CNT_W'(max_arity_q);
    row_m1    = CNT_W'(row_q) - CNT_W'(1);
    if (col_q == SIZE_W'(1)) begin
      step_lim = (top_arity < row_m1) ? top_arity : row_m1;
    end else begin
      step_lim = CNT_W'(row_q) - CNT_W'(col_q) + CNT_W'(1);
    end
  end

  // sequencer: fill any unfilled rows, then read the answer; a bad request answers zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      n_q         <= '0;
      g_q         <= '0;
      k_q         <= '0;
      lim_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      // output register: load a finished result, or free it once taken
      if ((state_q == S_RESP) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        count_q     <= res_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_hit) begin
        fill_q <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_bad) begin
              res_q   <= '0;
              state_q <= S_RESP;
            end else begin
              n_q <= n_in;
              g_q <= g_in;
              if (fill_q >= n_in) begin
                state_q <= S_QRD;
              end else begin
                row_q   <= fill_q + SIZE_W'(1);
                col_q   <= SIZE_W'(1);
                state_q <= S_COL_SETUP;
              end
            end
          end
        end
        S_COL_SETUP: begin
          k_q     <= CNT_W'(1);
          lim_q   <= step_lim;
          state_q <= (step_lim == '0) ? S_DRAIN : S_ISSUE;
        end
        S_ISSUE: begin
          k_q <= k_q + CNT_W'(1);
          if (k_q == lim_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (col_q == row_q) begin
            fill_q <= row_q;
            if (row_q == n_q) begin
              state_q <= S_QRD;
            end else begin
              row_q   <= row_q + SIZE_W'(1);
              col_q   <= SIZE_W'(1);
              state_q <= S_COL_SETUP;
            end
          end else begin
            col_q   <= col_q + SIZE_W'(1);
            state_q <= S_COL_SETUP;
          end
        end
        S_QRD: begin
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          res_q   <= memo_rdata;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath control for the current step
  always_comb begin
    mac_ctl.issue   = (state_q == S_ISSUE);
    mac_ctl.use_sym = (col_q == SIZE_W'(1));
    mac_ctl.sym     = (int'(k_q) <= MAX_ARITY) ? sym_q[ARITY_W'(k_q)] : '0;
    mac_ctl.clear   = (state_q == S_COL_SETUP);
    mac_ctl.init    = ((row_q == SIZE_W'(1)) && (col_q == SIZE_W'(1))) ?
                      COUNT_W'(sym_q[0]) : '0;
  end

  // memo addressing: terms read row m-1, groups read row m-j
  always_comb begin
    memo_re     = (state_q == S_ISSUE) || (state_q == S_QRD);
    terms_raddr = IDX_W'(k_q - CNT_W'(1));
    if (state_q == S_QRD) begin
      memo_raddr = memo_addr(IDX_W'(n_q - SIZE_W'(1)), IDX_W'(g_q - SIZE_W'(1)));
    end else if (col_q == SIZE_W'(1)) begin
      memo_raddr = memo_addr(IDX_W'(row_q - SIZE_W'(2)), IDX_W'(k_q - CNT_W'(1)));
    end else begin
      memo_raddr = memo_addr(IDX_W'(CNT_W'(row_q) - k_q - CNT_W'(1)),
                             IDX_W'(col_q - SIZE_W'(2)));
    end
    memo_we     = (state_q == S_WRITE);
    memo_waddr  = memo_addr(IDX_W'(row_q - SIZE_W'(1)), IDX_W'(col_q - SIZE_W'(1)));
    terms_we    = (state_q == S_WRITE) && (col_q == SIZE_W'(1));
    terms_waddr = IDX_W'(row_q - SIZE_W'(1));
  end

  tcs_ram #(
    .DEPTH (MEMO_DEPTH),
    .WIDTH (COUNT_W)
  ) u_memo_ram (
    .clk_i   (clk_i),
    .we_i    (memo_we),
    .waddr_i (memo_waddr),
    .wdata_i (mac_acc),
    .re_i    (memo_re),
    .raddr_i (memo_raddr),
    .rdata_o (memo_rdata)
  );

  tcs_ram #(
    .DEPTH (MAX_SIZE),
    .WIDTH (COUNT_W)
  ) u_terms_ram (
    .clk_i   (clk_i),
    .we_i    (terms_we),
    .waddr_i (terms_waddr),
    .wdata_i (mac_acc),
    .re_i    (mac_ctl.issue),
    .raddr_i (terms_raddr),
    .rdata_o (terms_rdata)
  );

  tcs_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .terms_i (terms_rdata),
    .memo_i  (memo_rdata),
    .acc_o   (mac_acc),
    .busy_o  (mac_busy)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

  `TCS_ASSERT_IMPL(a_write_after_drain, clk_i, rst_ni, state_q == S_WRITE, !mac_busy,
                   "memo written before the accumulator settled")
  `TCS_ASSERT_IMPL(a_fill_in_order, clk_i, rst_ni, state_q == S_ISSUE,
                   row_q == fill_q + SIZE_W'(1), "row filled out of order")
  `TCS_ASSERT_IMPL(a_query_filled, clk_i, rst_ni, state_q == S_QRD, fill_q >= n_q,
                   "answer read from an unfilled row")

endmodule

`default_nettype wire
